/* rtl/core/skc_pkg.sv */
// shared types, constants and the per-round key function for the seed/key checker
`default_nettype none

package skc_pkg;

   localparam int unsigned ROUND_COUNT_DEFAULT = 17;
   localparam int unsigned DATA_W              = 32;
   localparam int unsigned TYPE_W              = 8;
   localparam int unsigned CSR_ADDR_W          = 2;

   localparam logic [CSR_ADDR_W-1:0] XOR_MASK_ADDR = '0;

   localparam logic [TYPE_W-1:0] SUPPORTED_TYPE = 8'd3;
   localparam logic [DATA_W-1:0] TEST_BIT       = 32'h0000_8000;
   localparam logic [DATA_W-1:0] MASK_RESET     = 32'h0000_3210;

   // payload that moves down the round pipeline
   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] key;
      logic              supported;
      logic              zero_seed;
   } skc_stage_type;

   function automatic logic [DATA_W-1:0] skc_round_fn(input logic [DATA_W-1:0] value,
                                                      input logic [DATA_W-1:0] mask);
      logic [DATA_W-1:0] result;
      if ((value & TEST_BIT) != '0) begin
         result = {value[DATA_W-2:0], 1'b0} ^ mask;
      end else if (value == DATA_W'(1)) begin
         result = value + DATA_W'(2);
      end else begin
         result = value + DATA_W'(1);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/skc_csr.sv */
// apb-style register port holding the xor mask
`default_nettype none

module skc_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [skc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [skc_pkg::DATA_W-1:0]     csr_pwdata,
   output logic      [skc_pkg::DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output logic      [skc_pkg::DATA_W-1:0]     xor_mask
);
   import skc_pkg::*;

   logic [DATA_W-1:0] mask_ff;
   logic [DATA_W-1:0] mask_in;
   logic              write_en;

   // the only register sits at byte address 0
   assign write_en = csr_psel && csr_penable && csr_pwrite && (csr_paddr == XOR_MASK_ADDR);

   always_comb begin
      mask_in = mask_ff;
      if (write_en) begin
         mask_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
      end else begin
         mask_ff <= mask_in;
      end
   end

   assign csr_prdata = mask_ff;
   assign csr_pready = 1'b1;
   assign xor_mask   = mask_ff;

endmodule

`default_nettype wire

/* rtl/core/skc_round.sv */
// one registered round of the key derivation
`default_nettype none

module skc_round (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire logic                       valid_prev,
   input  wire skc_pkg::skc_stage_type     data_prev,
   input  wire logic [skc_pkg::DATA_W-1:0] xor_mask,
   output logic                            valid_out,
   output skc_pkg::skc_stage_type          data_out
);
   import skc_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   skc_stage_type data_ff;
   skc_stage_type data_in;

   always_comb begin
      valid_in      = advance ? valid_prev : valid_ff;
      data_in       = data_ff;
      if (advance) begin
         data_in       = data_prev;
         data_in.value = skc_round_fn(data_prev.value, xor_mask);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

`default_nettype wire

/* rtl/core/skc_compare.sv */
// final stage: zero-seed and unsupported-type handling, key compare, output register
`default_nettype none

module skc_compare (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic                        valid_prev,
   input  wire skc_pkg::skc_stage_type      data_prev,
   output logic                             rsp_valid,
   output logic [skc_pkg::DATA_W-1:0]       rsp_expected_key,
   output logic                             rsp_key_match,
   output logic                             rsp_type_supported
);
   import skc_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [DATA_W-1:0] key_ff;
   logic [DATA_W-1:0] key_in;
   logic              match_ff;
   logic              match_in;
   logic              supp_ff;
   logic              supp_in;
   logic [DATA_W-1:0] derived;

   always_comb begin
      derived  = (data_prev.supported && !data_prev.zero_seed) ? data_prev.value : '0;
      valid_in = advance ? valid_prev : valid_ff;
      key_in   = key_ff;
      match_in = match_ff;
      supp_in  = supp_ff;
      if (advance) begin
         key_in   = derived;
         match_in = data_prev.supported && (data_prev.key == derived);
         supp_in  = data_prev.supported;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      match_ff <= match_in;
      supp_ff  <= supp_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_expected_key   = key_ff;
   assign rsp_key_match      = match_ff;
   assign rsp_type_supported = supp_ff;

endmodule

`default_nettype wire

/* rtl/core/seed_key_check.sv */
// top level of the security-access seed/key checker
`default_nettype none

// Security-access key checker. Each request transaction carries an access type, a seed and
// the tester's key; the response gives the expected key, a match flag and a supported flag.
// Only access type 3 is supported: the expected key is the seed run through ROUND_COUNT
// rounds (shift left and xor with the mask when bit 15 is set, else add 2 when the value is
// one, else add 1); a zero seed yields key zero. Other types answer key zero, no match.
// The rounds form a pipeline of one register stage per round plus an output stage, so the
// first stage loads at the accepting edge and each later stage registers the request in turn
// until rsp_valid rises; one request is taken every cycle while the output is empty or
// rsp_ready is high; the whole pipeline holds while the output register waits on rsp_ready.
// The xor mask (reset 0x3210) is written through the csr port at address 0 and should only
// be changed while no request is in flight.
module seed_key_check #(
   parameter int unsigned ROUND_COUNT = skc_pkg::ROUND_COUNT_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [skc_pkg::TYPE_W-1:0]     req_access_type,
   input  wire logic [skc_pkg::DATA_W-1:0]     req_seed_value,
   input  wire logic [skc_pkg::DATA_W-1:0]     req_key_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [skc_pkg::DATA_W-1:0]     rsp_expected_key,
   output logic                                rsp_key_match,
   output logic                                rsp_type_supported,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [skc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [skc_pkg::DATA_W-1:0]     csr_pwdata,
   output logic      [skc_pkg::DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import skc_pkg::*;

   logic              advance;
   logic [DATA_W-1:0] xor_mask;
   logic              stage_valid [ROUND_COUNT+1];
   skc_stage_type     stage_data  [ROUND_COUNT+1];

   // every stage moves together unless a finished response is stuck at the output
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   skc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .xor_mask    (xor_mask)
   );

   assign stage_valid[0]          = req_valid;
   assign stage_data[0].value     = req_seed_value;
   assign stage_data[0].key       = req_key_value;
   assign stage_data[0].supported = (req_access_type == SUPPORTED_TYPE);
   assign stage_data[0].zero_seed = (req_seed_value == '0);

   for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
      skc_round u_round (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .valid_prev (stage_valid[r]),
         .data_prev  (stage_data[r]),
         .xor_mask   (xor_mask),
         .valid_out  (stage_valid[r+1]),
         .data_out   (stage_data[r+1])
      );
   end

   skc_compare u_compare (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .valid_prev         (stage_valid[ROUND_COUNT]),
      .data_prev          (stage_data[ROUND_COUNT]),
      .rsp_valid          (rsp_valid),
      .rsp_expected_key   (rsp_expected_key),
      .rsp_key_match      (rsp_key_match),
      .rsp_type_supported (rsp_type_supported)
   );

   a_unsupported_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_type_supported) |-> (rsp_expected_key == '0 && !rsp_key_match))
      else $error("unsupported type gave a nonzero key or a match");

   a_match_needs_type : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_key_match) |-> rsp_type_supported)
      else $error("key match flagged without a supported type");

   a_ready_follows_output : assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready out of step with output stall");

   a_empty_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

`default_nettype wire
